/* design/hex_text_signed_vlq_decoder_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the hex text signed VLQ decoder
// Each check samples on posedge clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HEX_TEXT_SIGNED_VLQ_DECODER_TOP_MACROS_SVH
`define HEX_TEXT_SIGNED_VLQ_DECODER_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define HVLQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hvlq assertion failed");

// Next-cycle implication.
`define HVLQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hvlq assertion failed");

`else

`define HVLQ_ASSERT_IMPL(label, ante, cons)
`define HVLQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* design/hvlq_pkg.sv */
// ----------------------------------------------------------------------------
// hvlq_pkg
// Types and constants shared by the hex text signed VLQ decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hvlq_pkg;

  // Width of the accumulator that builds a number (valid range 8 to 64).
  localparam int VALUE_WIDTH = 32;

  localparam logic [7:0] SIGN_START_MASK = 8'h40;
  localparam logic [7:0] CONTINUE_MASK   = 8'h80;
  localparam logic [7:0] END_BYTE        = 8'h7f;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_FORMAT_ERR = 1'b1;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] tag_value;
    logic               status;
  } out_item_t;

  // Classification of one character.
  typedef struct packed {
    logic       is_digit;
    logic       is_space;
    logic [3:0] nibble;
  } char_class_t;

endpackage

/* design/hvlq_char_decode.sv */
// ----------------------------------------------------------------------------
// hvlq_char_decode
// Classifies one character as hex digit, skippable whitespace or other.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hvlq_char_decode (
  input  logic [7:0]                char_code,
  output hvlq_pkg::char_class_t     char_class
);
  import hvlq_pkg::*;

  always_comb begin
    char_class          = '0;
    char_class.is_space = (char_code == CHAR_SPACE) || (char_code == CHAR_NEWLINE);
    if (char_code inside {[8'h30:8'h39]}) begin
      char_class.is_digit = 1'b1;
      char_class.nibble   = char_code[3:0];
    end else if ((char_code inside {[8'h61:8'h66]}) ||
                 (char_code inside {[8'h41:8'h46]})) begin
      // Letters a-f and A-F share their low bits: 1..6 maps to 10..15.
      char_class.is_digit = 1'b1;
      char_class.nibble   = char_code[3:0] + 4'd9;
    end
  end

endmodule

/* design/hex_text_signed_vlq_decoder_top.sv */
// ----------------------------------------------------------------------------
// hex_text_signed_vlq_decoder_top
// Decodes hex text into signed variable-length numbers, high group first.
// ----------------------------------------------------------------------------
// Output: a result is on out_valid in the cycle after the transfer that ends it.
// Throughput: one character per cycle; the input stalls only while a finished
// result sits in the output register and the receiver stalls it.
// Reset: synchronous, active low; clears the held nibble, the accumulator,
// the in-number flag and the output valid.
`timescale 1ns / 1ps

`include "hex_text_signed_vlq_decoder_top_macros.svh"

module hex_text_signed_vlq_decoder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hvlq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hvlq_pkg::out_item_t out_data
);
  import hvlq_pkg::*;

  // Decoder state. The accumulator holds VALUE_WIDTH bits of the number
  // being built; inside_r is set once a continuation byte has been seen.
  logic [3:0]             pend_r,   pend_nxt;
  logic                   held_r,   held_nxt;
  logic [VALUE_WIDTH-1:0] acc_r,    acc_nxt;
  logic                   inside_r, inside_nxt;

  // Output register.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r,  out_data_nxt;

  char_class_t char_class;
  logic        in_fire;
  logic        out_fire;

  // Per-item combinational results.
  logic                   byte_ready;
  logic [7:0]             byte_val;
  logic [VALUE_WIDTH-1:0] acc_base;
  logic [VALUE_WIDTH-1:0] acc_shift;
  logic signed [VALUE_WIDTH-1:0] acc_signed;
  logic                   res_valid;
  out_item_t              res_item;

  hvlq_char_decode u_char_decode (
    .char_code  (in_data.char_code),
    .char_class (char_class)
  );

  // The input is held back only when the output register is full and the
  // receiver is not taking it this cycle; otherwise a new transfer can land
  // alongside the one leaving.
  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;

  // Byte assembly. A byte is formed by the second digit of a pair, or by an
  // end of input at a pair boundary, which stands for the closing byte 0x7f.
  always_comb begin
    byte_ready = 1'b0;
    byte_val   = END_BYTE;
    if (in_data.end_of_input) begin
      byte_ready = !held_r;
    end else if (held_r && char_class.is_digit) begin
      byte_ready = 1'b1;
      byte_val   = {pend_r, char_class.nibble};
    end
  end

  // The first byte of a number seeds the accumulator with 0 or all ones
  // from its bit 6; every byte then shifts in its low seven bits.
  assign acc_base   = inside_r ? acc_r :
                      ((byte_val & SIGN_START_MASK) != 8'h00) ? '1 : '0;
  assign acc_shift  = {acc_base[VALUE_WIDTH-8:0], byte_val[6:0]};
  assign acc_signed = acc_shift;

  always_comb begin
    pend_nxt           = pend_r;
    held_nxt           = held_r;
    acc_nxt            = acc_r;
    inside_nxt         = inside_r;
    res_valid          = 1'b0;
    res_item.tag_value = '0;
    res_item.status    = STATUS_OK;

    if (in_data.end_of_input && held_r) begin
      // End of input in the middle of a pair is a format error.
      res_valid       = 1'b1;
      res_item.status = STATUS_FORMAT_ERR;
      pend_nxt        = '0;
      held_nxt        = 1'b0;
      acc_nxt         = '0;
      inside_nxt      = 1'b0;
    end else if (byte_ready) begin
      pend_nxt = '0;
      held_nxt = 1'b0;
      if ((byte_val & CONTINUE_MASK) != 8'h00) begin
        acc_nxt    = acc_shift;
        inside_nxt = 1'b1;
      end else begin
        // Last byte: sign-extend or wrap the accumulator to 32 bits.
        res_valid          = 1'b1;
        res_item.tag_value = 32'(acc_signed);
        acc_nxt            = '0;
        inside_nxt         = 1'b0;
      end
    end else if (!held_r && char_class.is_space) begin
      // Whitespace between pairs is skipped without a result.
    end else if (!char_class.is_digit) begin
      // Any other character, whitespace inside a pair included, is an error.
      res_valid       = 1'b1;
      res_item.status = STATUS_FORMAT_ERR;
      pend_nxt        = '0;
      held_nxt        = 1'b0;
      acc_nxt         = '0;
      inside_nxt      = 1'b0;
    end else begin
      // First digit of a pair.
      pend_nxt = char_class.nibble;
      held_nxt = 1'b1;
    end
  end

  // Output register: loads when an accepted item yields a result, drops its
  // valid once the receiver takes the transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire && res_valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      held_r      <= 1'b0;
      acc_r       <= '0;
      inside_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        pend_r   <= pend_nxt;
        held_r   <= held_nxt;
        acc_r    <= acc_nxt;
        inside_r <= inside_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // End of input with half a byte held must report a format error.
  `HVLQ_ASSERT_NEXT(a_eoi_midpair_err, in_fire && in_data.end_of_input && held_r, out_valid_r && out_data_r.status == STATUS_FORMAT_ERR)
  // Every result leaves the decoder at a number boundary with no half byte.
  `HVLQ_ASSERT_NEXT(a_result_clears, in_fire && res_valid, !inside_r && !held_r && acc_r == '0)
  // A format error always carries a zero value.
  `HVLQ_ASSERT_IMPL(a_err_zero, out_valid_r && out_data_r.status == STATUS_FORMAT_ERR, out_data_r.tag_value == '0)

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench for the hex text signed VLQ decoder
// Feeds text characters and end-of-input markers through the valid/stall
// channel, predicts every decoded number or format error in step with each
// accepted transfer, and checks each result transfer against the oldest
// prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import hvlq_pkg::*;

  // A watchdog ends the run after this many cycles without any transfer.
  // The longest quiet stretch in a correct run is a sender gap followed by a
  // receiver stall burst, or a drain pause behind one stall burst.
  localparam int HANG_LIMIT = 2000;

  // Stop idling on both sides once this few characters remain to be sent.
  localparam int QUIET_TAIL = 60;

  // One entry of the send queue. An entry with hold_for_drain set sends
  // nothing. The sender stops there until every predicted result has arrived.
  typedef struct {
    in_item_t item;
    bit       hold_for_drain;
  } feed_entry_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  feed_entry_t char_feed[$];
  out_item_t   predicted_results[$];

  int mismatch_count = 0;
  int quiet_cycles = 0;

  // Idle and stall control. The percentages are picked again from time to time,
  // so some stretches have heavy idling and others have none.
  int send_gap_pct = 20;
  int stall_pct = 20;
  int send_gap_left = 0;
  int stall_left = 0;
  bit quiet_tail = 1'b0;

  // Shadow copy of the decoder state, kept at the package accumulator width.
  logic [3:0]             dec_nibble = '0;
  logic                   dec_nibble_held = 1'b0;
  logic [VALUE_WIDTH-1:0] dec_acc = '0;
  logic                   dec_in_number = 1'b0;

  always #6 clk = ~clk;

  hex_text_signed_vlq_decoder_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // --------------------------------------------------------------------------
  // Decoder prediction
  // --------------------------------------------------------------------------

  task automatic clear_decoder();
    dec_nibble = '0;
    dec_nibble_held = 1'b0;
    dec_acc = '0;
    dec_in_number = 1'b0;
  endtask

  // Shifts one byte into the number being built. The first byte of a number
  // seeds the accumulator with all zeros or all ones from its sign-start bit.
  // A byte without the continue bit ends the number. The accumulator is then
  // sign-extended and cut to 32 bits.
  task automatic absorb_byte(input logic [7:0] b, output bit produced,
                             output out_item_t res);
    logic [VALUE_WIDTH-1:0] acc;
    logic [63:0]            wide;
    acc = dec_acc;
    res = '0;
    produced = 1'b0;
    if (!dec_in_number) begin
      acc = ((b & SIGN_START_MASK) != 0) ? '1 : '0;
    end
    acc = (acc << 7) | VALUE_WIDTH'(b & END_BYTE);
    if ((b & CONTINUE_MASK) != 0) begin
      dec_acc = acc;
      dec_in_number = 1'b1;
    end else begin
      wide = 64'(signed'(acc));
      res.tag_value = wide[31:0];
      res.status = STATUS_OK;
      produced = 1'b1;
      dec_acc = '0;
      dec_in_number = 1'b0;
    end
  endtask

  // Advances the shadow decoder by one accepted character or end marker.
  task automatic decode_char(input in_item_t it, output bit produced,
                             output out_item_t res);
    logic [7:0] c;
    logic [3:0] digit;
    bit         is_hex;
    c = it.char_code;
    res = '0;
    produced = 1'b0;
    is_hex = 1'b1;
    digit = '0;
    if (it.end_of_input) begin
      // End of input between pairs acts as a closing byte. In mid-pair it is a
      // format error.
      if (dec_nibble_held) begin
        clear_decoder();
        res.status = STATUS_FORMAT_ERR;
        produced = 1'b1;
      end else begin
        absorb_byte(END_BYTE, produced, res);
      end
    end else if (!dec_nibble_held && (c == CHAR_SPACE || c == CHAR_NEWLINE)) begin
      // Whitespace between pairs is skipped.
    end else begin
      if (c >= "0" && c <= "9") begin
        digit = 4'(c - "0");
      end else if (c >= "a" && c <= "f") begin
        digit = 4'(c - "a" + 10);
      end else if (c >= "A" && c <= "F") begin
        digit = 4'(c - "A" + 10);
      end else begin
        is_hex = 1'b0;
      end
      if (!is_hex) begin
        clear_decoder();
        res.status = STATUS_FORMAT_ERR;
        produced = 1'b1;
      end else if (!dec_nibble_held) begin
        dec_nibble = digit;
        dec_nibble_held = 1'b1;
      end else begin
        dec_nibble_held = 1'b0;
        absorb_byte({dec_nibble, digit}, produced, res);
        dec_nibble = '0;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) begin
      return 8'h30 + {4'h0, n};
    end
    return (upper ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
  endfunction

  task automatic push_char(input logic [7:0] c);
    feed_entry_t e;
    e.item.char_code = c;
    e.item.end_of_input = 1'b0;
    e.hold_for_drain = 1'b0;
    char_feed.push_back(e);
  endtask

  // The character code of an end marker is random, since the block ignores it.
  task automatic push_end();
    feed_entry_t e;
    e.item.char_code = 8'($urandom_range(255));
    e.item.end_of_input = 1'b1;
    e.hold_for_drain = 1'b0;
    char_feed.push_back(e);
  endtask

  task automatic push_drain();
    feed_entry_t e;
    e.item = '0;
    e.hold_for_drain = 1'b1;
    char_feed.push_back(e);
  endtask

  // One byte as two hex digits, each in a random letter case.
  task automatic push_byte(input logic [7:0] b);
    push_char(hex_char(b[7:4], 1'($urandom_range(1))));
    push_char(hex_char(b[3:0], 1'($urandom_range(1))));
  endtask

  task automatic push_space();
    push_char($urandom_range(1) ? CHAR_SPACE : CHAR_NEWLINE);
  endtask

  // --------------------------------------------------------------------------
  // Sender: holds each transfer until it is accepted. Gaps come in bursts.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : sender
    feed_entry_t head;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      send_gap_left <= 0;
    end else begin
      quiet_tail <= (char_feed.size() < QUIET_TAIL);
      if ($urandom_range(199) == 0) begin
        send_gap_pct <= $urandom_range(0, 40);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap_left != 0) begin
          in_valid <= 1'b0;
          send_gap_left <= send_gap_left - 1;
        end else if (char_feed.size() != 0 && char_feed[0].hold_for_drain) begin
          // Nothing was offered this cycle and no result is on the way, so the
          // prediction queue cannot change at this edge.
          in_valid <= 1'b0;
          if (!in_valid && !out_valid && predicted_results.size() == 0) begin
            head = char_feed.pop_front();
          end
        end else if (char_feed.size() != 0) begin
          head = char_feed.pop_front();
          in_valid <= 1'b1;
          in_data <= head.item;
          if (!quiet_tail && $urandom_range(99) < send_gap_pct) begin
            send_gap_left <= $urandom_range(1, 10);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stalls the result channel in bursts.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if ($urandom_range(199) == 0) begin
        stall_pct <= $urandom_range(0, 40);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!quiet_tail && $urandom_range(99) < stall_pct) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 9);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compares each result transfer with the oldest prediction and then
  // predicts from the character transfer at the same edge. A result always
  // belongs to an earlier character, so that order is safe.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    out_item_t want;
    out_item_t fresh;
    bit        made;
    if (!rst_n) begin
      clear_decoder();
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $error("result with nothing predicted: tag_value %0d status %0d",
                 out_data.tag_value, out_data.status);
          mismatch_count++;
        end else begin
          want = predicted_results.pop_front();
          if (out_data.tag_value !== want.tag_value) begin
            $error("tag_value: expected %0d, got %0d", want.tag_value, out_data.tag_value);
            mismatch_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        decode_char(in_data, made, fresh);
        if (made) begin
          predicted_results.push_back(fresh);
        end
      end
    end
  end

  // Watchdog: counts cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int         kind;
    int         len;
    logic [7:0] b;

    rst_n = 1'b0;

    // Directed part. Zero, whitespace between pairs, mixed-case digits.
    push_char("0");
    push_char("0");
    push_char(CHAR_SPACE);
    push_char(CHAR_NEWLINE);
    // A negative start carried on by two continuation bytes, then closed below.
    push_char("C");
    push_char("0");
    push_char("a");
    push_char("B");
    // End of input twice: the first closes that number, the second gives -1.
    push_end();
    push_end();
    // A number left open and then closed by end of input.
    push_char("8");
    push_char("1");
    push_end();
    // The sign-start bit on a one-byte number.
    push_char("4");
    push_char("0");
    // A bad digit, whitespace in mid-pair, and end of input in mid-pair.
    push_char("g");
    push_char("3");
    push_char(CHAR_SPACE);
    push_char("f");
    push_end();
    // The two extreme character codes, both bad digits.
    push_char(8'h00);
    push_char(8'hff);
    // Sender pause until every predicted result has arrived.
    push_drain();

    // Random part. Most of it is well-formed numbers. The rest is numbers
    // closed by end of input, pairs broken in the middle, and raw noise.
    while (char_feed.size() < 900) begin
      kind = $urandom_range(99);
      if (kind < 72) begin
        // Lengths past four bytes overflow the accumulator.
        len = ($urandom_range(7) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          b = 8'($urandom_range(255));
          b[7] = (k != len - 1);
          push_byte(b);
          if ($urandom_range(5) == 0) begin
            push_space();
          end
        end
      end else if (kind < 80) begin
        len = $urandom_range(0, 3);
        for (int k = 0; k < len; k++) begin
          b = 8'($urandom_range(255));
          b[7] = 1'b1;
          push_byte(b);
        end
        push_end();
      end else if (kind < 90) begin
        push_char(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
        case ($urandom_range(2))
          0: push_space();
          1: push_end();
          default: push_char(8'($urandom_range(255)));
        endcase
      end else begin
        push_char(8'($urandom_range(255)));
      end
      if ($urandom_range(249) == 0) begin
        push_drain();
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Sample at the falling edge so the clocked blocks have settled.
    do begin
      @(negedge clk);
    end while (char_feed.size() != 0 || in_valid || predicted_results.size() != 0);
    // A result appears in the cycle after its character. Leave room for a stray one.
    repeat (8) @(negedge clk);

    if (predicted_results.size() != 0) begin
      $error("%0d predicted results never arrived", predicted_results.size());
    end
    if (mismatch_count == 0 && predicted_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/hvlq_pkg.sv
design/hvlq_char_decode.sv
design/hex_text_signed_vlq_decoder_top.sv
sim/testbench.sv
